// ===== rtl/per_cpu_page_allocator_with_steal_macros.svh =====
// Assertion macros used by the allocator controller.
`ifndef PER_CPU_PAGE_ALLOCATOR_WITH_STEAL_MACROS_SVH
`define PER_CPU_PAGE_ALLOCATOR_WITH_STEAL_MACROS_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define PCPA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle.
`define PCPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/pcpa_pkg.sv =====
// Package with types, constants and codes of the per-CPU page allocator.
package pcpa_pkg;
    localparam int NUM_CPUS   = 8;
    localparam int NUM_PAGES  = 4096;
    localparam logic [31:0] BASE_ADDR = 32'h8000_0000;
    localparam logic [31:0] TOP_ADDR  = 32'h8100_0000;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = 12;
    localparam int CPU_W   = $clog2(NUM_CPUS) > 0 ? $clog2(NUM_CPUS) : 1;
    localparam int PAGE_W  = $clog2(NUM_PAGES);
    localparam int LEN_W   = $clog2(NUM_PAGES + 1);
    localparam int PER_CPU = NUM_PAGES / NUM_CPUS;
    localparam logic [32:0] FIRST_PAGE =
        33'((64'(BASE_ADDR) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES) * 64'(PAGE_BYTES));

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OOM = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic        action;
        logic [2:0]  cpu;
        logic [31:0] address;
    } req_t;

    typedef struct packed {
        logic [31:0] page_address;
        logic [1:0]  status;
    } rsp_t;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DECODE, S_FREE_CHK, S_POP_RD, S_POP_WB, S_SCAN,
        S_WALK, S_RESP
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic init_step;
        logic load_req;
        logic check_free;
        logic push;
        logic link_read_head;
        logic pop_commit;
        logic scan_step;
        logic walk_start;
        logic walk_step;
        logic steal_commit;
        logic set_oom;
        logic set_bad;
    } cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic init_done;
        logic is_free;
        logic cpu_ok;
        logic own_nonempty;
        logic free_ok;
        logic scan_hit;
        logic scan_end;
        logic walk_done;
    } sts_t;

    // Reset owner of page p.
    function automatic logic [CPU_W-1:0] init_owner(input logic [PAGE_W-1:0] p);
        logic [31:0] c;
        c = 32'(p) / 32'(PER_CPU);
        if (c >= 32'(NUM_CPUS)) c = 32'd0;
        return CPU_W'(c);
    endfunction
endpackage

// ===== rtl/pcpa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module pcpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/pcpa_datapath.sv =====
// Datapath: link and free-bit memories, list heads and lengths, steal walker.
module pcpa_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  pcpa_pkg::req_t req,
    input  pcpa_pkg::cmd_t cmd,
    output pcpa_pkg::sts_t sts,
    output logic           free_bit,
    output pcpa_pkg::rsp_t rsp
);
    import pcpa_pkg::*;

    req_t              req_reg;
    logic [PAGE_W:0]   init_cnt_reg;
    logic [PAGE_W-1:0] head_reg [NUM_CPUS];
    logic [LEN_W-1:0]  len_reg  [NUM_CPUS];
    logic [CPU_W:0]    scan_reg;
    logic [LEN_W-1:0]  walk_cnt_reg;
    logic [LEN_W-1:0]  take_reg;
    logic [PAGE_W-1:0] node_reg;
    logic [PAGE_W-1:0] idx_reg;
    rsp_t              rsp_reg;

    logic              link_we, free_we, free_wd;
    logic [PAGE_W-1:0] link_wa, link_wd, link_ra, free_wa, free_ra;
    logic [PAGE_W-1:0] link_rd;
    logic              free_rd;

    logic [CPU_W-1:0]  cpu;
    logic [CPU_W-1:0]  victim;
    logic [32:0]       off;
    logic              addr_ok;
    logic [PAGE_W-1:0] init_p;
    logic [CPU_W-1:0]  init_c;
    logic [PAGE_W-1:0] init_prev;

    assign cpu    = req_reg.cpu[CPU_W-1:0];
    assign victim = scan_reg[CPU_W-1:0];
    assign off    = {1'b0, req_reg.address} - FIRST_PAGE;
    assign addr_ok = (req_reg.address[PAGE_SHIFT-1:0] == '0)
                  && ({1'b0, req_reg.address} >= FIRST_PAGE)
                  && (req_reg.address < TOP_ADDR)
                  && (off[32:PAGE_SHIFT] < 21'(NUM_PAGES));
    assign init_p = init_cnt_reg[PAGE_W-1:0];
    assign init_c = init_owner(init_p);
    // Each page links to the previous page pushed on the same list.
    always_comb
    begin
        init_prev = init_p - PAGE_W'(1);
        if (32'(init_p) == 32'(NUM_CPUS * PER_CPU) && NUM_CPUS * PER_CPU < NUM_PAGES)
        begin
            init_prev = PAGE_W'(PER_CPU - 1);
        end
    end

    pcpa_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PAGES)) u_link (
        .clk(clk), .we(link_we), .waddr(link_wa), .wdata(link_wd),
        .raddr(link_ra), .rdata(link_rd)
    );
    pcpa_ram #(.WIDTH(1), .DEPTH(NUM_PAGES)) u_free (
        .clk(clk), .we(free_we), .waddr(free_wa), .wdata(free_wd),
        .raddr(free_ra), .rdata(free_rd)
    );

    always_comb
    begin
        link_we = 1'b0;
        link_wa = idx_reg;
        link_wd = head_reg[cpu];
        free_we = 1'b0;
        free_wa = idx_reg;
        free_wd = 1'b1;
        free_ra = off[PAGE_SHIFT+PAGE_W-1:PAGE_SHIFT];
        link_ra = head_reg[cpu];
        if (cmd.init_step)
        begin
            link_we = 1'b1;
            link_wa = init_p;
            link_wd = init_prev;
            free_we = 1'b1;
            free_wa = init_p;
        end
        if (cmd.push)
        begin
            link_we = 1'b1;
            free_we = 1'b1;
        end
        if (cmd.pop_commit)
        begin
            free_we = 1'b1;
            free_wa = head_reg[cpu];
            free_wd = 1'b0;
        end
        if (cmd.steal_commit)
        begin
            free_we = 1'b1;
            free_wa = head_reg[victim];
            free_wd = 1'b0;
        end
        if (cmd.walk_start)
        begin
            link_ra = head_reg[victim];
        end
        if (cmd.walk_step)
        begin
            link_ra = link_rd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_cnt_reg <= '0;
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                head_reg[i] <= '0;
                len_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cmd.init_step)
            begin
                init_cnt_reg <= init_cnt_reg + 1'b1;
                head_reg[init_c] <= init_p;
                len_reg[init_c]  <= len_reg[init_c] + 1'b1;
            end
            if (cmd.push)
            begin
                head_reg[cpu] <= idx_reg;
                len_reg[cpu]  <= len_reg[cpu] + 1'b1;
            end
            if (cmd.pop_commit)
            begin
                len_reg[cpu] <= len_reg[cpu] - 1'b1;
                if (len_reg[cpu] != LEN_W'(1))
                begin
                    head_reg[cpu] <= link_rd;
                end
            end
            if (cmd.steal_commit)
            begin
                // Victim keeps the tail; requester gets the run minus its first page.
                len_reg[victim] <= len_reg[victim] - take_reg;
                if (len_reg[victim] != take_reg)
                begin
                    head_reg[victim] <= link_rd;
                end
                len_reg[cpu] <= take_reg - 1'b1;
                if (take_reg != LEN_W'(1))
                begin
                    head_reg[cpu] <= node_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg  <= req;
            scan_reg <= '0;
            rsp_reg  <= '{page_address: 32'd0, status: ST_OK};
        end
        if (cmd.check_free)
        begin
            idx_reg <= off[PAGE_SHIFT+PAGE_W-1:PAGE_SHIFT];
        end
        if (cmd.scan_step)
        begin
            scan_reg <= scan_reg + 1'b1;
        end
        if (cmd.walk_start)
        begin
            take_reg     <= (len_reg[victim] >> 1) + 1'b1;
            walk_cnt_reg <= LEN_W'(1);
        end
        if (cmd.walk_step)
        begin
            walk_cnt_reg <= walk_cnt_reg + 1'b1;
            if (walk_cnt_reg == LEN_W'(1))
            begin
                node_reg <= link_rd;
            end
        end
        if (cmd.pop_commit)
        begin
            rsp_reg.page_address <= 32'(FIRST_PAGE + {head_reg[cpu], PAGE_SHIFT'(0)});
        end
        if (cmd.steal_commit)
        begin
            rsp_reg.page_address <= 32'(FIRST_PAGE + {head_reg[victim], PAGE_SHIFT'(0)});
        end
        if (cmd.set_oom) rsp_reg.status <= ST_OOM;
        if (cmd.set_bad) rsp_reg.status <= ST_BAD;
    end

    assign sts.init_done    = (init_cnt_reg == (PAGE_W+1)'(NUM_PAGES));
    assign sts.is_free      = (req_reg.action == ACT_FREE);
    assign sts.cpu_ok       = (32'(req_reg.cpu) < 32'(NUM_CPUS));
    assign sts.own_nonempty = (len_reg[cpu] != '0);
    assign sts.free_ok      = addr_ok;
    assign sts.scan_end     = (32'(scan_reg) >= 32'(NUM_CPUS));
    assign sts.scan_hit     = !sts.scan_end && (victim != cpu) && (len_reg[victim] != '0);
    assign sts.walk_done    = (walk_cnt_reg >= take_reg);
    assign rsp = rsp_reg;
    // Free bit of the addressed page, valid in the cycle after the check.
    assign free_bit = free_rd;
endmodule

// ===== rtl/pcpa_ctrl.sv =====
// Controller state machine of the allocator.
module pcpa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  pcpa_pkg::sts_t sts,
    input  logic           free_bit,
    output pcpa_pkg::cmd_t cmd
);
    import pcpa_pkg::*;
    `include "per_cpu_page_allocator_with_steal_macros.svh"

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_INIT;
        else        state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                if (sts.init_done) state_next = S_IDLE;
                else               cmd.init_step = 1'b1;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.is_free)
                begin
                    if (sts.cpu_ok && sts.free_ok)
                    begin
                        cmd.check_free = 1'b1;
                        state_next = S_FREE_CHK;
                    end
                    else
                    begin
                        cmd.set_bad = 1'b1;
                        state_next = S_RESP;
                    end
                end
                else if (!sts.cpu_ok)
                begin
                    cmd.set_oom = 1'b1;
                    state_next = S_RESP;
                end
                else if (sts.own_nonempty)
                begin
                    state_next = S_POP_RD;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_FREE_CHK:
            begin
                if (free_bit) cmd.set_bad = 1'b1;
                else          cmd.push = 1'b1;
                state_next = S_RESP;
            end
            S_POP_RD:
            begin
                state_next = S_POP_WB;
            end
            S_POP_WB:
            begin
                cmd.pop_commit = 1'b1;
                state_next = S_RESP;
            end
            S_SCAN:
            begin
                if (sts.scan_end)
                begin
                    cmd.set_oom = 1'b1;
                    state_next = S_RESP;
                end
                else if (sts.scan_hit)
                begin
                    cmd.walk_start = 1'b1;
                    state_next = S_WALK;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_WALK:
            begin
                // The link read out now follows the last stolen page.
                if (sts.walk_done)
                begin
                    cmd.steal_commit = 1'b1;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_RESP:
            begin
                out_valid = 1'b1;
                if (out_ready) state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    `PCPA_ASSERT_IMP(a_no_accept_in_init, clk, rst_n, state_reg == S_INIT, !in_ready, "input taken during init")
    `PCPA_ASSERT_IMP(a_excl, clk, rst_n, in_ready, !out_valid, "ready and valid both high")
    `PCPA_ASSERT_NEXT(a_resp_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
endmodule

// ===== rtl/per_cpu_page_allocator_with_steal.sv =====
// Per-CPU page allocator with stealing: top level.
// Reset runs an init sweep (one link per cycle); in_ready rises in the cycle after init_done.
// Free: S_DECODE, S_FREE_CHK, S_RESP (a bad address skips S_FREE_CHK). Plain allocate: S_DECODE,
// S_POP_RD, S_POP_WB, S_RESP. A steal scans CPUs in S_SCAN, then walks the run in S_WALK.
// Out of memory is a scan with no hit. One transaction is in flight at a time; in_ready returns in
// the cycle after the result is taken. Async active-low reset clears the FSM, init count and lists.
module per_cpu_page_allocator_with_steal (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  pcpa_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output pcpa_pkg::rsp_t out_data
);
    import pcpa_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic u_dp_free_bit;

    // The free bit of the addressed page is read from the datapath memory
    // during the check state; the controller uses it to reject a double free.
    pcpa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .sts(sts),
        .free_bit(u_dp_free_bit), .cmd(cmd)
    );

    pcpa_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .req(in_data), .cmd(cmd), .sts(sts),
        .free_bit(u_dp_free_bit), .rsp(out_data)
    );
endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the per-CPU page allocator with stealing.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pcpa_pkg::*;

    localparam int MAX_CYCLES = 20_000_000;
    localparam int MAX_SHOWN  = 10;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    req_t in_data;
    logic out_valid;
    logic out_ready;
    rsp_t out_data;

    per_cpu_page_allocator_with_steal u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Shadow of the allocator state: one LIFO list per CPU, linked through the
    // successor table, plus a bit per page saying whether it sits on a list.
    logic [PAGE_W-1:0] succ_page [NUM_PAGES];
    logic [PAGE_W-1:0] head_page [NUM_CPUS];
    int unsigned       list_len  [NUM_CPUS];
    bit                on_list   [NUM_PAGES];

    // Pages currently handed out, so that frees can give back real pages.
    logic [31:0] held_pages [$];
    rsp_t        expected_rsp [$];

    int  mismatch_count;
    bit  failed;
    int  cycle_count = 0;
    bit  hold_off = 1'b0;
    int  hold_cycles = 0;
    int  hold_requests = 0;
    int  hold_seen = 0;

    function automatic logic [31:0] page_to_addr(input int unsigned p);
        logic [32:0] a;
        a = FIRST_PAGE + 33'(p) * 33'(PAGE_BYTES);
        return a[31:0];
    endfunction

    function automatic void push_onto(input int unsigned c, input int unsigned p);
        succ_page[p] = head_page[c];
        head_page[c] = PAGE_W'(p);
        list_len[c]++;
        on_list[p] = 1'b1;
    endfunction

    function automatic int unsigned pop_from(input int unsigned c);
        int unsigned p;
        p = 32'(head_page[c]);
        list_len[c]--;
        if (list_len[c] != 0)
            head_page[c] = succ_page[p];
        on_list[p] = 1'b0;
        return p;
    endfunction

    function automatic void reset_pool();
        for (int c = 0; c < NUM_CPUS; c++)
        begin
            head_page[c] = '0;
            list_len[c]  = 0;
        end
        for (int p = 0; p < NUM_PAGES; p++)
        begin
            succ_page[p] = '0;
            on_list[p]   = 1'b0;
        end
        for (int c = 0; c < NUM_CPUS; c++)
            for (int p = c * PER_CPU; p < (c + 1) * PER_CPU; p++)
                push_onto(c, p);
        for (int p = NUM_CPUS * PER_CPU; p < NUM_PAGES; p++)
            push_onto(0, p);
    endfunction

    // Works out the response of one request and advances the shadow state.
    function automatic rsp_t allocator_response(input req_t rq);
        rsp_t        r;
        logic [32:0] a;
        logic [32:0] idx;
        bit          ok;
        bit          found;
        int unsigned n;
        int unsigned take;
        int unsigned node;
        int unsigned first;
        int unsigned c;
        r.page_address = '0;
        r.status       = ST_OK;
        c = 32'(rq.cpu);
        a = {1'b0, rq.address};
        if (rq.action == ACT_FREE)
        begin
            ok = c < NUM_CPUS;
            if (ok && (a[PAGE_SHIFT-1:0] != '0 || a < FIRST_PAGE || a >= {1'b0, TOP_ADDR}))
                ok = 1'b0;
            if (ok)
            begin
                idx = (a - FIRST_PAGE) >> PAGE_SHIFT;
                if (idx >= NUM_PAGES || on_list[idx])
                    ok = 1'b0;
            end
            if (ok)
                push_onto(c, 32'(idx));
            else
                r.status = ST_BAD;
        end
        else if (c >= NUM_CPUS)
            r.status = ST_OOM;
        else if (list_len[c] != 0)
            r.page_address = page_to_addr(pop_from(c));
        else
        begin
            found = 1'b0;
            for (int v = 0; v < NUM_CPUS; v++)
            begin
                if (found || v == c || list_len[v] == 0)
                    continue;
                found = 1'b1;
                n     = list_len[v];
                take  = n / 2 + 1;
                first = 32'(head_page[v]);
                node  = first;
                for (int k = 1; k < take; k++)
                    node = 32'(succ_page[node]);
                list_len[v] = n - take;
                if (list_len[v] != 0)
                    head_page[v] = succ_page[node];
                head_page[c] = PAGE_W'(first);
                list_len[c]  = take;
                r.page_address = page_to_addr(pop_from(c));
            end
            if (!found)
                r.status = ST_OOM;
        end
        return r;
    endfunction

    function automatic int short_or_long_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // Offers one transaction, waits until it is taken and records the expectation.
    // Stretches of back-to-back items happen when random gaps come out zero.
    task automatic send_request(input logic act, input logic [2:0] c, input logic [31:0] a);
        req_t rq;
        rsp_t r;
        int   gap;
        rq.action  = act;
        rq.cpu     = c;
        rq.address = a;
        gap = short_or_long_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= rq;
        do
            @(posedge clk);
        while (!in_ready);
        r = allocator_response(rq);
        expected_rsp.push_back(r);
        if (act == ACT_ALLOC && r.status == ST_OK)
            held_pages.push_back(r.page_address);
    endtask

    task automatic alloc_page(input logic [2:0] c);
        send_request(ACT_ALLOC, c, $urandom);
    endtask

    // Frees a page held at random, or sends a random address when none is held.
    task automatic free_held(input logic [2:0] c);
        int          i;
        logic [31:0] a;
        if (held_pages.size() == 0)
            a = $urandom;
        else
        begin
            i = $urandom_range(0, held_pages.size() - 1);
            a = held_pages[i];
            held_pages.delete(i);
        end
        send_request(ACT_FREE, c, a);
    endtask

    // Receiver side: random stalls, plus a long hold-off when requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_off)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
        end
    end

    // Hold-off counter runs in its own process: a long hold when a test asks
    // for one, and now and then a shorter random stall.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            hold_off    <= 1'b1;
        end
        else if (hold_seen != hold_requests)
        begin
            hold_seen   <= hold_requests;
            hold_cycles <= 300;
            hold_off    <= 1'b1;
        end
        else if ($urandom_range(0, 149) == 0)
        begin
            hold_cycles <= $urandom_range(10, 60);
            hold_off    <= 1'b1;
        end
        else
        begin
            hold_off <= 1'b0;
        end
    end

    // Compares each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                failed = 1'b1;
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN)
                    $display("unexpected result: page_address=%h status=%0d",
                             out_data.page_address, out_data.status);
            end
            else
            begin
                rsp_t e;
                e = expected_rsp.pop_front();
                if (e.page_address !== out_data.page_address || e.status !== out_data.status)
                begin
                    failed = 1'b1;
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN)
                        $display("result mismatch: expected page_address=%h status=%0d, %s",
                                 e.page_address, e.status,
                                 $sformatf("got page_address=%h status=%0d",
                                           out_data.page_address, out_data.status));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Field extremes and each special case: misaligned, below the pool, at the
    // top address, a double free, and the extremes.
    task automatic test_directed();
        send_request(ACT_FREE, 3'd0, 32'h0000_0000);
        send_request(ACT_FREE, 3'd7, 32'hFFFF_FFFF);
        send_request(ACT_FREE, 3'd1, BASE_ADDR + 32'd4);
        send_request(ACT_FREE, 3'd2, BASE_ADDR - 32'(PAGE_BYTES));
        send_request(ACT_FREE, 3'd3, TOP_ADDR);
        send_request(ACT_FREE, 3'd4, page_to_addr(NUM_PAGES - 1));
        send_request(ACT_FREE, 3'd5, BASE_ADDR);
        send_request(ACT_ALLOC, 3'd0, 32'hFFFF_FFFF);
        send_request(ACT_ALLOC, 3'd7, 32'h0000_0000);
        alloc_page(3'd3);
        free_held(3'd6);
        free_held(3'd2);
        send_request(ACT_FREE, 3'd1, page_to_addr(NUM_PAGES - 1));
        alloc_page(3'd5);
    endtask

    // Drains CPU 1 so that its next allocation steals, then spreads pages around.
    task automatic test_steal();
        for (int i = 0; i < PER_CPU + 3; i++)
            alloc_page(3'd1);
        for (int i = 0; i < 8; i++)
            free_held(3'($urandom_range(0, 7)));
    endtask

    // Allocates a run of pages, then gives pages back. The receiver holds off
    // part way so the block stalls its input.
    task automatic test_backpressure();
        int taken;
        taken = 0;
        while (taken < 200)
        begin
            if (taken == 40)
                hold_requests++;
            alloc_page(3'($urandom_range(0, 7)));
            taken++;
        end
        for (int i = 0; i < 3; i++)
            alloc_page(3'($urandom_range(0, 7)));
        for (int i = 0; i < 100; i++)
            free_held(3'($urandom_range(0, 7)));
    endtask

    // Mostly well-formed alloc and free traffic, some bad frees.
    task automatic test_random(input int count);
        int          pick;
        logic [31:0] a;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 48)
                alloc_page(3'($urandom_range(0, 7)));
            else if (pick < 88)
                free_held(3'($urandom_range(0, 7)));
            else
            begin
                if ($urandom_range(0, 1) == 0)
                    a = $urandom;
                else
                    a = page_to_addr($urandom_range(0, NUM_PAGES - 1)) | 32'($urandom_range(0, 1));
                send_request(ACT_FREE, 3'($urandom_range(0, 7)), a);
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        mismatch_count = 0;
        failed         = 1'b0;
        reset_pool();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_steal();
        test_random(600);
        test_backpressure();
        in_valid <= 1'b0;

        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (!failed && expected_rsp.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/pcpa_pkg.sv
rtl/pcpa_ram.sv
rtl/pcpa_datapath.sv
rtl/pcpa_ctrl.sv
rtl/per_cpu_page_allocator_with_steal.sv
dv/tb.sv
